### rtl/assert_macros.svh
// Assertion helpers shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge out of reset.
`define UOI_ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds out of reset.
`define UOI_ASSERT_NEVER(label, expr, msg) \
  `UOI_ASSERT_PROP(label, !(expr), msg)

`endif

### rtl/uoi_pkg.sv
package uoi_pkg;

  // CORDIC sizing
  localparam int CORDIC_STEPS = 24;
  localparam int COR_CNT_W = $clog2(CORDIC_STEPS);
  localparam int ANG_W = 34;

  // divider sizing: 68-bit numerator, 4 quotient bits a cycle
  localparam int DIV_W = 68;
  localparam int DEN_W = 32;
  localparam int DIV_BITS = 4;
  localparam int DIV_STEPS = DIV_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // shared multiplier
  localparam int MUL_W = 34;
  localparam int PROD_W = 2 * MUL_W;

  // fixed-point constants
  localparam logic signed [ANG_W-1:0] PI_Q29 = 34'sd1686629713;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ANG_W-1:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [ANG_W-1:0] ONE_Q30 = 34'sd1073741824;
  localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [MUL_W-1:0] NS_PER_S = 34'sd1000000000;
  localparam logic [DEN_W-1:0] TWO_PI_Q29 = 32'd3373259426;
  localparam logic [DEN_W-1:0] DIV_Q29 = 32'd1953125;
  localparam logic [DEN_W-1:0] NS_PER_S_U = 32'd1000000000;

  typedef enum logic [5:0] {
    ST_IDLE, ST_DISPATCH, ST_SP_DIV, ST_SP_WAIT, ST_NOW_MUL, ST_NOW, ST_DT,
    ST_P_MUL, ST_DTH_DIV, ST_DTH_WAIT, ST_HALF_DIV, ST_HALF_WAIT, ST_ANG_OLD,
    ST_CI_START, ST_CI_WAIT, ST_WX_MUL, ST_WY_MUL, ST_WY, ST_PX_MUL, ST_PX_DIV,
    ST_PX_WAIT, ST_PY_MUL, ST_PY_DIV, ST_PY_WAIT, ST_HD_DIV, ST_HD_WAIT,
    ST_CN_START, ST_CN_WAIT, ST_OX_MUL, ST_OY_MUL, ST_OY, ST_CQ_START,
    ST_CQ_WAIT, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    MS_NONE, MS_NOW, MS_P, MS_VC, MS_VS, MS_WX, MS_WY
  } mul_sel_t;

  typedef enum logic [2:0] {
    DS_SETPOSE, DS_DTH, DS_HALF, DS_PX, DS_PY, DS_HEAD
  } div_sel_t;

  typedef enum logic [1:0] {
    CS_INT, CS_NEW, CS_QUAT
  } cor_sel_t;

  typedef enum logic [4:0] {
    WR_NONE, WR_LOAD, WR_SETPOSE, WR_NOW, WR_DT, WR_DTH, WR_ANG_WRAP,
    WR_ANG_OLD, WR_CS, WR_WVX, WR_WVY, WR_PX, WR_PY, WR_HEAD, WR_OVX, WR_OVY,
    WR_QUAT, WR_OUT
  } wr_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    logic     div_start;
    div_sel_t div_sel;
    logic     cor_start;
    cor_sel_t cor_sel;
    wr_t      wr;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic cor_done;
    logic func;
    logic stamp_valid;
    logic mode;
    logic out_free;
  } sts_t;

  // arctangent of 2^-i in Q2.30
  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    case (idx)
      5'd0: return 32'd843314857;
      5'd1: return 32'd497837829;
      5'd2: return 32'd263043837;
      5'd3: return 32'd133525159;
      5'd4: return 32'd67021687;
      5'd5: return 32'd33543516;
      5'd6: return 32'd16775851;
      5'd7: return 32'd8388437;
      5'd8: return 32'd4194283;
      5'd9: return 32'd2097149;
      5'd10: return 32'd1048576;
      5'd11: return 32'd524288;
      5'd12: return 32'd262144;
      5'd13: return 32'd131072;
      5'd14: return 32'd65536;
      5'd15: return 32'd32768;
      5'd16: return 32'd16384;
      5'd17: return 32'd8192;
      5'd18: return 32'd4096;
      5'd19: return 32'd2048;
      5'd20: return 32'd1024;
      5'd21: return 32'd512;
      5'd22: return 32'd256;
      5'd23: return 32'd128;
      5'd24: return 32'd64;
      5'd25: return 32'd32;
      5'd26: return 32'd16;
      5'd27: return 32'd8;
      5'd28: return 32'd4;
      5'd29: return 32'd2;
      5'd30: return 32'd1;
      default: return 32'd0;
    endcase
  endfunction

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'sd2147483647;
    if (v < -36'sd2147483648) return {1'b1, 31'd0};
    return v[31:0];
  endfunction

endpackage

### rtl/uoi_div.sv
module uoi_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [uoi_pkg::DIV_W-1:0]     num,
  input  logic        [uoi_pkg::DEN_W-1:0]     den_in,
  output logic                                 done,
  output logic signed [uoi_pkg::DIV_W-1:0]     quo_out,
  output logic        [uoi_pkg::DEN_W-1:0]     rem_out
);

  logic                              busy;
  logic [uoi_pkg::DIV_CNT_W-1:0]     cnt;
  logic [uoi_pkg::DEN_W-1:0]         rem;
  logic [uoi_pkg::DIV_W-1:0]         quo;
  logic [uoi_pkg::DEN_W-1:0]         den;
  logic                              neg;
  logic [uoi_pkg::DEN_W-1:0]         rem_next;
  logic [uoi_pkg::DIV_W-1:0]         quo_next;
  logic [uoi_pkg::DEN_W:0]           trial;

  // advance the restoring division by DIV_BITS quotient bits
  always_comb begin
    rem_next = rem;
    quo_next = quo;
    trial = '0;
    for (int k = 0; k < uoi_pkg::DIV_BITS; k++) begin
      trial = {rem_next, quo_next[uoi_pkg::DIV_W-1]};
      quo_next = {quo_next[uoi_pkg::DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem_next = uoi_pkg::DEN_W'(trial - {1'b0, den});
        quo_next[0] = 1'b1;
      end else begin
        rem_next = trial[uoi_pkg::DEN_W-1:0];
      end
    end
  end

  // sequence the iterations; negative numerators divide their complement
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == uoi_pkg::DIV_CNT_W'(uoi_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[uoi_pkg::DIV_W-1];
      quo <= num[uoi_pkg::DIV_W-1] ? ~num : num;
      rem <= '0;
      den <= den_in;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  // map back to floor quotient and non-negative remainder
  assign quo_out = neg ? ~quo : quo;
  assign rem_out = neg ? (den - rem - 1'b1) : rem;

endmodule

### rtl/uoi_cordic.sv
module uoi_cordic (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [uoi_pkg::ANG_W-1:0]    angle,
  output logic                                done,
  output logic signed [31:0]                  cos_out,
  output logic signed [31:0]                  sin_out
);

  logic                              busy;
  logic [uoi_pkg::COR_CNT_W-1:0]     cnt;
  logic signed [uoi_pkg::ANG_W-1:0]  x;
  logic signed [uoi_pkg::ANG_W-1:0]  y;
  logic signed [uoi_pkg::ANG_W-1:0]  z;
  logic                              neg;
  logic signed [uoi_pkg::ANG_W-1:0]  z_fold;
  logic                              neg_fold;
  logic signed [uoi_pkg::ANG_W-1:0]  xs;
  logic signed [uoi_pkg::ANG_W-1:0]  ys;
  logic signed [uoi_pkg::ANG_W-1:0]  atan_step;
  logic signed [uoi_pkg::ANG_W-1:0]  xf;
  logic signed [uoi_pkg::ANG_W-1:0]  yf;

  // fold the angle into [-pi/2, pi/2]
  always_comb begin
    z_fold = angle;
    neg_fold = 1'b0;
    if (angle > uoi_pkg::HALF_PI_Q30) begin
      z_fold = angle - uoi_pkg::PI_Q30;
      neg_fold = 1'b1;
    end else if (angle < -uoi_pkg::HALF_PI_Q30) begin
      z_fold = angle + uoi_pkg::PI_Q30;
      neg_fold = 1'b1;
    end
  end

  assign xs = x >>> cnt;
  assign ys = y >>> cnt;
  assign atan_step = $signed({2'b00, uoi_pkg::atan_q30(5'(cnt))});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == uoi_pkg::COR_CNT_W'(uoi_pkg::CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // rotate one micro-step per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      x <= uoi_pkg::CORDIC_GAIN;
      y <= '0;
      z <= z_fold;
      neg <= neg_fold;
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - atan_step;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + atan_step;
      end
    end
  end

  // undo the fold and clamp to unity
  always_comb begin
    xf = neg ? -x : x;
    yf = neg ? -y : y;
    if (xf > uoi_pkg::ONE_Q30) xf = uoi_pkg::ONE_Q30;
    if (xf < -uoi_pkg::ONE_Q30) xf = -uoi_pkg::ONE_Q30;
    if (yf > uoi_pkg::ONE_Q30) yf = uoi_pkg::ONE_Q30;
    if (yf < -uoi_pkg::ONE_Q30) yf = -uoi_pkg::ONE_Q30;
  end

  assign cos_out = xf[31:0];
  assign sin_out = yf[31:0];

endmodule

### rtl/uoi_dpath.sv
module uoi_dpath (
  input  logic                clk,
  input  logic                rst,
  input  uoi_pkg::cmd_t       cmd,
  output uoi_pkg::sts_t       sts,
  input  logic                cfg_valid,
  input  logic                cfg_data,
  input  logic                func,
  input  logic [31:0]         stamp_sec,
  input  logic [29:0]         stamp_nsec,
  input  logic signed [31:0]  lin_vel,
  input  logic signed [31:0]  ang_vel,
  input  logic signed [31:0]  new_x,
  input  logic signed [31:0]  new_y,
  input  logic signed [31:0]  new_heading,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  pos_x_out,
  output logic signed [31:0]  pos_y_out,
  output logic signed [31:0]  heading_out,
  output logic signed [31:0]  quat_z,
  output logic signed [31:0]  quat_w,
  output logic signed [31:0]  world_vel_x,
  output logic signed [31:0]  world_vel_y,
  output logic signed [31:0]  yaw_rate_out,
  output logic [31:0]         out_sec,
  output logic [29:0]         out_nsec,
  output logic                mode_used
);

  // configuration and pose state
  logic                      mode;
  logic                      mode_cur;
  logic signed [31:0]        pose_x;
  logic signed [31:0]        pose_y;
  logic signed [31:0]        pose_h;
  logic [62:0]               prev_ns;
  logic                      stamp_valid;

  // captured transaction
  logic                      item_func;
  logic [31:0]               item_sec;
  logic [29:0]               item_nsec;
  logic signed [31:0]        item_v;
  logic signed [31:0]        item_w;
  logic signed [31:0]        item_x;
  logic signed [31:0]        item_y;
  logic signed [31:0]        item_h;

  // working registers
  logic [62:0]                         now_ns;
  logic signed [31:0]                  dt;
  logic signed [47:0]                  dth;
  logic signed [31:0]                  ang;
  logic signed [31:0]                  c_reg;
  logic signed [31:0]                  s_reg;
  logic signed [uoi_pkg::MUL_W-1:0]    wvx;
  logic signed [uoi_pkg::MUL_W-1:0]    wvy;
  logic signed [31:0]                  ovx;
  logic signed [31:0]                  ovy;
  logic signed [31:0]                  qz;
  logic signed [31:0]                  qw;
  logic signed [uoi_pkg::PROD_W-1:0]   prod;

  // unit connections
  logic signed [uoi_pkg::MUL_W-1:0]    mul_a;
  logic signed [uoi_pkg::MUL_W-1:0]    mul_b;
  logic signed [uoi_pkg::DIV_W-1:0]    div_num;
  logic [uoi_pkg::DEN_W-1:0]           div_den;
  logic                                div_done;
  logic signed [uoi_pkg::DIV_W-1:0]    div_quo;
  logic [uoi_pkg::DEN_W-1:0]           div_rem;
  logic signed [uoi_pkg::ANG_W-1:0]    cor_angle;
  logic                                cor_done;
  logic signed [31:0]                  cor_c;
  logic signed [31:0]                  cor_s;

  // derived values
  logic signed [uoi_pkg::ANG_W-1:0]    wrapped_w;
  logic signed [31:0]                  wrapped;
  logic signed [63:0]                  diff;
  logic signed [35:0]                  px_sum;
  logic signed [35:0]                  py_sum;
  logic signed [35:0]                  wv_prod;
  logic                                out_free;

  // select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      uoi_pkg::MS_NOW: begin
        mul_a = $signed({2'b00, item_sec});
        mul_b = uoi_pkg::NS_PER_S;
      end
      uoi_pkg::MS_P: begin
        mul_a = uoi_pkg::MUL_W'(item_w);
        mul_b = uoi_pkg::MUL_W'(dt);
      end
      uoi_pkg::MS_VC: begin
        mul_a = uoi_pkg::MUL_W'(item_v);
        mul_b = uoi_pkg::MUL_W'(c_reg);
      end
      uoi_pkg::MS_VS: begin
        mul_a = uoi_pkg::MUL_W'(item_v);
        mul_b = uoi_pkg::MUL_W'(s_reg);
      end
      uoi_pkg::MS_WX: begin
        mul_a = wvx;
        mul_b = uoi_pkg::MUL_W'(dt);
      end
      uoi_pkg::MS_WY: begin
        mul_a = wvy;
        mul_b = uoi_pkg::MUL_W'(dt);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // register each product
  always_ff @(posedge clk) begin
    if (cmd.mul_sel != uoi_pkg::MS_NONE) prod <= mul_a * mul_b;
  end

  // select divider operands
  always_comb begin
    div_num = '0;
    div_den = uoi_pkg::TWO_PI_Q29;
    case (cmd.div_sel)
      uoi_pkg::DS_SETPOSE: begin
        div_num = uoi_pkg::DIV_W'(item_h) + uoi_pkg::DIV_W'(uoi_pkg::PI_Q29);
      end
      uoi_pkg::DS_DTH: begin
        div_num = $signed({prod[63:0], 4'b0000});
        div_den = uoi_pkg::DIV_Q29;
      end
      uoi_pkg::DS_HALF: begin
        div_num = uoi_pkg::DIV_W'(pose_h) + uoi_pkg::DIV_W'(dth >>> 1)
                + uoi_pkg::DIV_W'(uoi_pkg::PI_Q29);
      end
      uoi_pkg::DS_PX, uoi_pkg::DS_PY: begin
        div_num = prod;
        div_den = uoi_pkg::NS_PER_S_U;
      end
      uoi_pkg::DS_HEAD: begin
        div_num = uoi_pkg::DIV_W'(pose_h) + uoi_pkg::DIV_W'(dth)
                + uoi_pkg::DIV_W'(uoi_pkg::PI_Q29);
      end
      default: begin
        div_num = '0;
      end
    endcase
  end

  uoi_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .num     (div_num),
    .den_in  (div_den),
    .done    (div_done),
    .quo_out (div_quo),
    .rem_out (div_rem)
  );

  // select the CORDIC angle in Q4.30
  always_comb begin
    case (cmd.cor_sel)
      uoi_pkg::CS_INT:  cor_angle = $signed({ang[31], ang, 1'b0});
      uoi_pkg::CS_NEW:  cor_angle = $signed({pose_h[31], pose_h, 1'b0});
      uoi_pkg::CS_QUAT: cor_angle = uoi_pkg::ANG_W'(pose_h);
      default:          cor_angle = '0;
    endcase
  end

  uoi_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.cor_start),
    .angle   (cor_angle),
    .done    (cor_done),
    .cos_out (cor_c),
    .sin_out (cor_s)
  );

  // wrapped heading, stamp delta, position sums, velocity product and output-free flag
  assign wrapped_w = $signed({2'b00, div_rem}) - uoi_pkg::PI_Q29;
  assign wrapped = wrapped_w[31:0];
  assign diff = $signed({1'b0, now_ns}) - $signed({1'b0, prev_ns});
  assign px_sum = 36'(pose_x) + 36'($signed(div_quo[34:0]));
  assign py_sum = 36'(pose_y) + 36'($signed(div_quo[34:0]));
  assign wv_prod = 36'($signed(prod[63:30]));
  assign out_free = !out_valid || !out_stall;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b1;
    end else if (cfg_valid) begin
      mode <= cfg_data;
    end
  end

  // pose and stamp state
  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x <= '0;
      pose_y <= '0;
      pose_h <= '0;
      prev_ns <= '0;
      stamp_valid <= 1'b0;
    end else begin
      case (cmd.wr)
        uoi_pkg::WR_SETPOSE: begin
          pose_x <= item_x;
          pose_y <= item_y;
          pose_h <= wrapped;
        end
        uoi_pkg::WR_DT: begin
          prev_ns <= now_ns;
          stamp_valid <= 1'b1;
        end
        uoi_pkg::WR_PX:   pose_x <= uoi_pkg::sat32(px_sum);
        uoi_pkg::WR_PY:   pose_y <= uoi_pkg::sat32(py_sum);
        uoi_pkg::WR_HEAD: pose_h <= wrapped;
        default: begin
        end
      endcase
    end
  end

  // capture the transaction and working values
  always_ff @(posedge clk) begin
    case (cmd.wr)
      uoi_pkg::WR_LOAD: begin
        item_func <= func;
        item_sec <= stamp_sec;
        item_nsec <= stamp_nsec;
        item_v <= lin_vel;
        item_w <= ang_vel;
        item_x <= new_x;
        item_y <= new_y;
        item_h <= new_heading;
        mode_cur <= mode;
      end
      uoi_pkg::WR_NOW: now_ns <= prod[62:0] + 63'(item_nsec);
      uoi_pkg::WR_DT: begin
        if (diff > 64'sd2147483647) dt <= 32'sd2147483647;
        else if (diff < -64'sd2147483648) dt <= {1'b1, 31'd0};
        else dt <= diff[31:0];
      end
      uoi_pkg::WR_DTH:      dth <= div_quo[47:0];
      uoi_pkg::WR_ANG_WRAP: ang <= wrapped;
      uoi_pkg::WR_ANG_OLD:  ang <= pose_h;
      uoi_pkg::WR_CS: begin
        c_reg <= cor_c;
        s_reg <= cor_s;
      end
      uoi_pkg::WR_WVX: wvx <= prod[63:30];
      uoi_pkg::WR_WVY: wvy <= prod[63:30];
      uoi_pkg::WR_OVX: ovx <= uoi_pkg::sat32(wv_prod);
      uoi_pkg::WR_OVY: ovy <= uoi_pkg::sat32(wv_prod);
      uoi_pkg::WR_QUAT: begin
        qw <= cor_c;
        qz <= cor_s;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.wr == uoi_pkg::WR_OUT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr == uoi_pkg::WR_OUT) begin
      pos_x_out <= pose_x;
      pos_y_out <= pose_y;
      heading_out <= pose_h;
      quat_z <= qz;
      quat_w <= qw;
      world_vel_x <= ovx;
      world_vel_y <= ovy;
      yaw_rate_out <= item_w;
      out_sec <= item_sec;
      out_nsec <= item_nsec;
      mode_used <= mode_cur;
    end
  end

  // status back to the controller
  assign sts.div_done = div_done;
  assign sts.cor_done = cor_done;
  assign sts.func = item_func;
  assign sts.stamp_valid = stamp_valid;
  assign sts.mode = mode_cur;
  assign sts.out_free = out_free;

endmodule

### rtl/uoi_ctrl.sv
module uoi_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  uoi_pkg::sts_t  sts,
  output logic           in_stall,
  output uoi_pkg::cmd_t  cmd
);

  uoi_pkg::state_t state;
  uoi_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= uoi_pkg::ST_IDLE;
    else state <= state_next;
  end

  // sequence one transaction through the datapath
  always_comb begin
    state_next = state;
    case (state)
      uoi_pkg::ST_IDLE:     if (in_valid) state_next = uoi_pkg::ST_DISPATCH;
      uoi_pkg::ST_DISPATCH: state_next = sts.func ? uoi_pkg::ST_SP_DIV : uoi_pkg::ST_NOW_MUL;
      uoi_pkg::ST_SP_DIV:   state_next = uoi_pkg::ST_SP_WAIT;
      uoi_pkg::ST_SP_WAIT:  if (sts.div_done) state_next = uoi_pkg::ST_IDLE;
      uoi_pkg::ST_NOW_MUL:  state_next = uoi_pkg::ST_NOW;
      uoi_pkg::ST_NOW:      state_next = uoi_pkg::ST_DT;
      uoi_pkg::ST_DT:       state_next = sts.stamp_valid ? uoi_pkg::ST_P_MUL : uoi_pkg::ST_IDLE;
      uoi_pkg::ST_P_MUL:    state_next = uoi_pkg::ST_DTH_DIV;
      uoi_pkg::ST_DTH_DIV:  state_next = uoi_pkg::ST_DTH_WAIT;
      uoi_pkg::ST_DTH_WAIT: begin
        if (sts.div_done) state_next = sts.mode ? uoi_pkg::ST_HALF_DIV : uoi_pkg::ST_ANG_OLD;
      end
      uoi_pkg::ST_HALF_DIV:  state_next = uoi_pkg::ST_HALF_WAIT;
      uoi_pkg::ST_HALF_WAIT: if (sts.div_done) state_next = uoi_pkg::ST_CI_START;
      uoi_pkg::ST_ANG_OLD:   state_next = uoi_pkg::ST_CI_START;
      uoi_pkg::ST_CI_START:  state_next = uoi_pkg::ST_CI_WAIT;
      uoi_pkg::ST_CI_WAIT:   if (sts.cor_done) state_next = uoi_pkg::ST_WX_MUL;
      uoi_pkg::ST_WX_MUL:    state_next = uoi_pkg::ST_WY_MUL;
      uoi_pkg::ST_WY_MUL:    state_next = uoi_pkg::ST_WY;
      uoi_pkg::ST_WY:        state_next = uoi_pkg::ST_PX_MUL;
      uoi_pkg::ST_PX_MUL:    state_next = uoi_pkg::ST_PX_DIV;
      uoi_pkg::ST_PX_DIV:    state_next = uoi_pkg::ST_PX_WAIT;
      uoi_pkg::ST_PX_WAIT:   if (sts.div_done) state_next = uoi_pkg::ST_PY_MUL;
      uoi_pkg::ST_PY_MUL:    state_next = uoi_pkg::ST_PY_DIV;
      uoi_pkg::ST_PY_DIV:    state_next = uoi_pkg::ST_PY_WAIT;
      uoi_pkg::ST_PY_WAIT:   if (sts.div_done) state_next = uoi_pkg::ST_HD_DIV;
      uoi_pkg::ST_HD_DIV:    state_next = uoi_pkg::ST_HD_WAIT;
      uoi_pkg::ST_HD_WAIT:   if (sts.div_done) state_next = uoi_pkg::ST_CN_START;
      uoi_pkg::ST_CN_START:  state_next = uoi_pkg::ST_CN_WAIT;
      uoi_pkg::ST_CN_WAIT:   if (sts.cor_done) state_next = uoi_pkg::ST_OX_MUL;
      uoi_pkg::ST_OX_MUL:    state_next = uoi_pkg::ST_OY_MUL;
      uoi_pkg::ST_OY_MUL:    state_next = uoi_pkg::ST_OY;
      uoi_pkg::ST_OY:        state_next = uoi_pkg::ST_CQ_START;
      uoi_pkg::ST_CQ_START:  state_next = uoi_pkg::ST_CQ_WAIT;
      uoi_pkg::ST_CQ_WAIT:   if (sts.cor_done) state_next = uoi_pkg::ST_OUT;
      uoi_pkg::ST_OUT:       if (sts.out_free) state_next = uoi_pkg::ST_IDLE;
      default:               state_next = uoi_pkg::ST_IDLE;
    endcase
  end

  // drive datapath commands for each state
  always_comb begin
    cmd = '0;
    in_stall = (state != uoi_pkg::ST_IDLE);
    case (state)
      uoi_pkg::ST_IDLE: if (in_valid) cmd.wr = uoi_pkg::WR_LOAD;
      uoi_pkg::ST_SP_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = uoi_pkg::DS_SETPOSE;
      end
      uoi_pkg::ST_SP_WAIT: if (sts.div_done) cmd.wr = uoi_pkg::WR_SETPOSE;
      uoi_pkg::ST_NOW_MUL: cmd.mul_sel = uoi_pkg::MS_NOW;
      uoi_pkg::ST_NOW:     cmd.wr = uoi_pkg::WR_NOW;
      uoi_pkg::ST_DT:      cmd.wr = uoi_pkg::WR_DT;
      uoi_pkg::ST_P_MUL:   cmd.mul_sel = uoi_pkg::MS_P;
      uoi_pkg::ST_DTH_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = uoi_pkg::DS_DTH;
      end
      uoi_pkg::ST_DTH_WAIT: if (sts.div_done) cmd.wr = uoi_pkg::WR_DTH;
      uoi_pkg::ST_HALF_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = uoi_pkg::DS_HALF;
      end
      uoi_pkg::ST_HALF_WAIT: if (sts.div_done) cmd.wr = uoi_pkg::WR_ANG_WRAP;
      uoi_pkg::ST_ANG_OLD:   cmd.wr = uoi_pkg::WR_ANG_OLD;
      uoi_pkg::ST_CI_START: begin
        cmd.cor_start = 1'b1;
        cmd.cor_sel = uoi_pkg::CS_INT;
      end
      uoi_pkg::ST_CI_WAIT: if (sts.cor_done) cmd.wr = uoi_pkg::WR_CS;
      uoi_pkg::ST_WX_MUL:  cmd.mul_sel = uoi_pkg::MS_VC;
      uoi_pkg::ST_WY_MUL: begin
        cmd.mul_sel = uoi_pkg::MS_VS;
        cmd.wr = uoi_pkg::WR_WVX;
      end
      uoi_pkg::ST_WY:     cmd.wr = uoi_pkg::WR_WVY;
      uoi_pkg::ST_PX_MUL: cmd.mul_sel = uoi_pkg::MS_WX;
      uoi_pkg::ST_PX_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = uoi_pkg::DS_PX;
      end
      uoi_pkg::ST_PX_WAIT: if (sts.div_done) cmd.wr = uoi_pkg::WR_PX;
      uoi_pkg::ST_PY_MUL:  cmd.mul_sel = uoi_pkg::MS_WY;
      uoi_pkg::ST_PY_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = uoi_pkg::DS_PY;
      end
      uoi_pkg::ST_PY_WAIT: if (sts.div_done) cmd.wr = uoi_pkg::WR_PY;
      uoi_pkg::ST_HD_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = uoi_pkg::DS_HEAD;
      end
      uoi_pkg::ST_HD_WAIT: if (sts.div_done) cmd.wr = uoi_pkg::WR_HEAD;
      uoi_pkg::ST_CN_START: begin
        cmd.cor_start = 1'b1;
        cmd.cor_sel = uoi_pkg::CS_NEW;
      end
      uoi_pkg::ST_CN_WAIT: if (sts.cor_done) cmd.wr = uoi_pkg::WR_CS;
      uoi_pkg::ST_OX_MUL:  cmd.mul_sel = uoi_pkg::MS_VC;
      uoi_pkg::ST_OY_MUL: begin
        cmd.mul_sel = uoi_pkg::MS_VS;
        cmd.wr = uoi_pkg::WR_OVX;
      end
      uoi_pkg::ST_OY: cmd.wr = uoi_pkg::WR_OVY;
      uoi_pkg::ST_CQ_START: begin
        cmd.cor_start = 1'b1;
        cmd.cor_sel = uoi_pkg::CS_QUAT;
      end
      uoi_pkg::ST_CQ_WAIT: if (sts.cor_done) cmd.wr = uoi_pkg::WR_QUAT;
      uoi_pkg::ST_OUT:     if (sts.out_free) cmd.wr = uoi_pkg::WR_OUT;
      default: begin
      end
    endcase
  end

endmodule

### rtl/unicycle_odometry_integrator_top.sv
// Planar unicycle odometry integrator: one transaction at a time, either a
// set-pose transaction or a velocity sample; each velocity sample after the
// first is integrated with midpoint Runge-Kutta or with Euler. The shared
// divider yields 4 quotient bits a cycle (17 steps a pass) and runs five times
// per sample with Runge-Kutta (heading step, midpoint wrap, x step, y step,
// heading wrap; four with Euler), beside three passes of the 24-step CORDIC.
// A finished result sits in the output register while the next transaction is
// accepted; integration_mode is sampled at acceptance.
`include "assert_macros.svh"

module unicycle_odometry_integrator_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                func,
  input  logic [31:0]         stamp_sec,
  input  logic [29:0]         stamp_nsec,
  input  logic signed [31:0]  lin_vel,
  input  logic signed [31:0]  ang_vel,
  input  logic signed [31:0]  new_x,
  input  logic signed [31:0]  new_y,
  input  logic signed [31:0]  new_heading,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  pos_x_out,
  output logic signed [31:0]  pos_y_out,
  output logic signed [31:0]  heading_out,
  output logic signed [31:0]  quat_z,
  output logic signed [31:0]  quat_w,
  output logic signed [31:0]  world_vel_x,
  output logic signed [31:0]  world_vel_y,
  output logic signed [31:0]  yaw_rate_out,
  output logic [31:0]         out_sec,
  output logic [29:0]         out_nsec,
  output logic                mode_used
);

  uoi_pkg::cmd_t cmd;
  uoi_pkg::sts_t sts;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  uoi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  uoi_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .func         (func),
    .stamp_sec    (stamp_sec),
    .stamp_nsec   (stamp_nsec),
    .lin_vel      (lin_vel),
    .ang_vel      (ang_vel),
    .new_x        (new_x),
    .new_y        (new_y),
    .new_heading  (new_heading),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pos_x_out    (pos_x_out),
    .pos_y_out    (pos_y_out),
    .heading_out  (heading_out),
    .quat_z       (quat_z),
    .quat_w       (quat_w),
    .world_vel_x  (world_vel_x),
    .world_vel_y  (world_vel_y),
    .yaw_rate_out (yaw_rate_out),
    .out_sec      (out_sec),
    .out_nsec     (out_nsec),
    .mode_used    (mode_used)
  );

  // an accepted transaction blocks the input until it is done
  `UOI_ASSERT_PROP(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall, "input not held off after accept")
  // a result is loaded only into a free output register
  `UOI_ASSERT_NEVER(a_out_overwrite, (cmd.wr == uoi_pkg::WR_OUT) && !sts.out_free, "output overwritten")
  // a new result shows up only from a load command
  `UOI_ASSERT_PROP(a_out_from_load, $rose(out_valid) |-> ($past(cmd.wr) == uoi_pkg::WR_OUT), "result without load")
  // divider completion is a single-cycle pulse
  `UOI_ASSERT_PROP(a_div_pulse, sts.div_done |=> !sts.div_done, "divider done held")

endmodule
